// ----- hdl/cw_keyer_envelope_macros.svh -----
// assertion macros shared by the checker of the cw keyer envelope block
// no dependencies; pulled in by `include where assertions are written
`ifndef CW_KEYER_ENVELOPE_MACROS_SVH
`define CW_KEYER_ENVELOPE_MACROS_SVH

// same-cycle implication, masked while reset is low
`define CWK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwk check failed");

// next-cycle implication, masked while reset is low
`define CWK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwk check failed");

`endif

// ----- hdl/cwk_pkg.sv -----
// types, phase codes and the dot length table of the cw keyer envelope block
// no dependencies; used by cwk_step and cw_keyer_envelope
package cwk_pkg;

  localparam int PWR_W  = 15;
  localparam int STEP_W = 9;
  localparam int DOT_W  = 11;
  localparam int DASH_W = 12;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DOT   = 2'd1;
  localparam logic [1:0] PH_DASH  = 2'd2;
  localparam logic [1:0] PH_SPACE = 2'd3;

  localparam logic [1:0] CFG_KEYER_EN = 2'd0;
  localparam logic [1:0] CFG_WPM      = 2'd1;
  localparam logic [1:0] CFG_HOLD     = 2'd2;

  localparam logic [6:0]  WPM_RESET  = 7'd20;
  localparam logic [15:0] HOLD_RESET = 16'd200;

  // floor(x / 100) for 15-bit x is (x * 5243) >> 19
  localparam logic [12:0] STEP_RECIP = 13'd5243;
  localparam int          STEP_SHIFT = 19;

  // 1200 / wpm in ms, zero speed taken as one word per minute
  localparam logic [DOT_W-1:0] DOT_LEN_LUT [0:127] = '{
    11'd1200, 11'd1200, 11'd600, 11'd400, 11'd300, 11'd240, 11'd200, 11'd171,
    11'd150,  11'd133,  11'd120, 11'd109, 11'd100, 11'd92,  11'd85,  11'd80,
    11'd75,   11'd70,   11'd66,  11'd63,  11'd60,  11'd57,  11'd54,  11'd52,
    11'd50,   11'd48,   11'd46,  11'd44,  11'd42,  11'd41,  11'd40,  11'd38,
    11'd37,   11'd36,   11'd35,  11'd34,  11'd33,  11'd32,  11'd31,  11'd30,
    11'd30,   11'd29,   11'd28,  11'd27,  11'd27,  11'd26,  11'd26,  11'd25,
    11'd25,   11'd24,   11'd24,  11'd23,  11'd23,  11'd22,  11'd22,  11'd21,
    11'd21,   11'd21,   11'd20,  11'd20,  11'd20,  11'd19,  11'd19,  11'd19,
    11'd18,   11'd18,   11'd18,  11'd17,  11'd17,  11'd17,  11'd17,  11'd16,
    11'd16,   11'd16,   11'd16,  11'd16,  11'd15,  11'd15,  11'd15,  11'd15,
    11'd15,   11'd14,   11'd14,  11'd14,  11'd14,  11'd14,  11'd13,  11'd13,
    11'd13,   11'd13,   11'd13,  11'd13,  11'd13,  11'd12,  11'd12,  11'd12,
    11'd12,   11'd12,   11'd12,  11'd12,  11'd12,  11'd11,  11'd11,  11'd11,
    11'd11,   11'd11,   11'd11,  11'd11,  11'd11,  11'd11,  11'd10,  11'd10,
    11'd10,   11'd10,   11'd10,  11'd10,  11'd10,  11'd10,  11'd10,  11'd10,
    11'd10,   11'd9,    11'd9,   11'd9,   11'd9,   11'd9,   11'd9,   11'd9
  };

  typedef struct packed {
    logic [1:0]       phase;
    logic [31:0]      start;
    logic [PWR_W-1:0] level;
  } cwk_state_t;

  typedef struct packed {
    logic [31:0]       now;
    logic [PWR_W-1:0]  power;
    logic [STEP_W-1:0] step;
    logic              dot;
    logic              dash;
    logic              serial;
    logic              ptt;
  } cwk_item_t;

  typedef struct packed {
    logic [PWR_W-1:0] envelope;
    logic             reload;
    logic [1:0]       phase;
  } cwk_result_t;

endpackage

// ----- hdl/cwk_step.sv -----
// one keyer/envelope step: next phase, element start and level from one word
// depends on cwk_pkg
module cwk_step import cwk_pkg::*; (
  input  logic                keyer_en,
  input  logic [DOT_W-1:0]    dot_len,
  input  logic [DASH_W-1:0]   dash_len,
  input  cwk_state_t          state,
  input  cwk_item_t           item,
  output cwk_state_t          state_nxt,
  output cwk_result_t         result
);

  logic [31:0] dot_es, dot_now, dash_es, dash_now;

  assign dot_es   = state.start + 32'(dot_len);
  assign dot_now  = item.now + 32'(dot_len);
  assign dash_es  = state.start + 32'(dash_len);
  assign dash_now = item.now + 32'(dash_len);

  always_comb begin
    logic [1:0]        ph;
    logic [31:0]       es;
    logic              from_now;
    logic              done;
    logic              rise;
    logic              reload;
    logic [31:0]       end_t;
    logic [PWR_W:0]    up;
    logic [PWR_W-1:0]  lvl;

    ph       = state.phase;
    es       = state.start;
    from_now = 1'b0;
    done     = 1'b0;
    rise     = 1'b0;
    reload   = 1'b0;
    end_t    = dot_es;
    up       = '0;
    lvl      = state.level;

    if (!keyer_en) begin
      rise = item.serial | item.ptt | item.dot | item.dash;
    end else begin
      if (ph == PH_IDLE && item.dot) begin
        ph       = PH_DOT;
        es       = item.now;
        from_now = 1'b1;
      end
      if (ph == PH_DOT) begin
        end_t = from_now ? dot_now : dot_es;
        if (end_t > item.now) begin
          reload = 1'b1;
          rise   = 1'b1;
          done   = 1'b1;
        end else if (end_t < item.now) begin
          ph       = PH_SPACE;
          es       = item.now;
          from_now = 1'b1;
        end
      end
      if (!done && ph == PH_IDLE && item.dash) begin
        ph       = PH_DASH;
        es       = item.now;
        from_now = 1'b1;
      end
      if (!done && ph == PH_DASH) begin
        end_t = from_now ? dash_now : dash_es;
        if (end_t > item.now) begin
          reload = 1'b1;
          rise   = 1'b1;
          done   = 1'b1;
        end else if (end_t < item.now) begin
          ph       = PH_SPACE;
          es       = item.now;
          from_now = 1'b1;
        end
      end
      if (!done && ph == PH_SPACE) begin
        // gap is one dot long, envelope keeps falling through it
        end_t = from_now ? dot_now : dot_es;
        if (end_t > item.now) begin
          reload = 1'b1;
        end else if (end_t < item.now) begin
          ph = PH_IDLE;
        end
      end
    end

    if (rise) begin
      up  = (state.level < item.power) ? ({1'b0, state.level} + (PWR_W+1)'(item.step))
                                      : {1'b0, state.level};
      lvl = (up > {1'b0, item.power}) ? item.power : up[PWR_W-1:0];
    end else begin
      lvl = (state.level > PWR_W'(item.step)) ? (state.level - PWR_W'(item.step)) : '0;
    end

    state_nxt.phase = ph;
    state_nxt.start = es;
    state_nxt.level = lvl;
    result.envelope = lvl;
    result.reload   = reload;
    result.phase    = ph;
  end

endmodule

// ----- hdl/cw_keyer_envelope.sv -----
// CW keyer envelope generator. Takes one word per clock unless stalled: a timestamp, the key
// lines and a target power. It gives one envelope word per input word, passed
// through the input register, then the result register, to the output. The rate
// is one word per cycle while the output is not stalled; it is set by the loop
// through cwk_step that updates phase, element start and envelope level before
// the next word uses them. A stalled output only holds the input side once both
// registers are full. cfg_ready is always high; configuration is meant to be
// written while no words are in flight. Dot length is looked up from the speed
// at write time.
// depends on cwk_pkg and cwk_step
module cw_keyer_envelope import cwk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_now_ms,
  input  logic [PWR_W-1:0]  in_target_power,
  input  logic              in_dot_key,
  input  logic              in_dash_key,
  input  logic              in_serial_key,
  input  logic              in_ptt_key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PWR_W-1:0]  out_envelope,
  output logic              out_hold_reload,
  output logic [15:0]       out_hold_value,
  output logic [1:0]        out_keyer_phase_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  logic              keyer_en_r;
  logic [DOT_W-1:0]  dot_len_r;
  logic [DASH_W-1:0] dash_len_r;
  logic [15:0]       hold_r;
  logic [DOT_W-1:0]  cfg_dot;

  logic              s1_valid_r;
  cwk_item_t         s1_item_r;
  cwk_item_t         item_nxt;
  logic [27:0]       step_prod;

  cwk_state_t        state_r;
  cwk_state_t        state_nxt;
  cwk_result_t       result;

  logic              out_valid_r;
  cwk_result_t       out_res_r;
  logic [15:0]       out_hold_r;
  logic              out_adv;
  logic              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign cfg_dot   = DOT_LEN_LUT[cfg_data[6:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keyer_en_r <= 1'b0;
      dot_len_r  <= DOT_LEN_LUT[WPM_RESET];
      dash_len_r <= (DASH_W'(DOT_LEN_LUT[WPM_RESET]) << 1) + DASH_W'(DOT_LEN_LUT[WPM_RESET]);
      hold_r     <= HOLD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_KEYER_EN: keyer_en_r <= cfg_data[0];
        CFG_WPM: begin
          dot_len_r  <= cfg_dot;
          dash_len_r <= (DASH_W'(cfg_dot) << 1) + DASH_W'(cfg_dot);
        end
        CFG_HOLD: hold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register can take a word when empty or being drained
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;

  // step = floor(power / 100) worked out ahead of the state loop
  assign step_prod = 28'(in_target_power) * 28'(STEP_RECIP);

  always_comb begin
    item_nxt.now    = in_now_ms;
    item_nxt.power  = in_target_power;
    item_nxt.step   = step_prod[STEP_SHIFT +: STEP_W];
    item_nxt.dot    = in_dot_key;
    item_nxt.dash   = in_dash_key;
    item_nxt.serial = in_serial_key;
    item_nxt.ptt    = in_ptt_key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= item_nxt;
    end
  end

  cwk_step u_step (
    .keyer_en  (keyer_en_r),
    .dot_len   (dot_len_r),
    .dash_len  (dash_len_r),
    .state     (state_r),
    .item      (s1_item_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{phase: PH_IDLE, start: 32'd0, level: '0};
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_res_r  <= result;
      out_hold_r <= hold_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_envelope        = out_res_r.envelope;
  assign out_hold_reload     = out_res_r.reload;
  assign out_hold_value      = out_hold_r;
  assign out_keyer_phase_out = out_res_r.phase;

endmodule

// ----- hdl/cwk_checker.sv -----
// port-level checks of the cw keyer envelope block, bound to its top level
// depends on cwk_pkg and cw_keyer_envelope_macros.svh
`include "cw_keyer_envelope_macros.svh"

module cwk_checker import cwk_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [PWR_W-1:0]  out_envelope,
  input logic              out_hold_reload,
  input logic [15:0]       out_hold_value,
  input logic [1:0]        out_keyer_phase_out
);

  // a held result word keeps its payload
  `CWK_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_envelope) && $stable(out_hold_reload) && $stable(out_hold_value) && $stable(out_keyer_phase_out))

  // input side only backs up when the result register is full and stalled
  `CWK_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // hold reload only comes from a running element or gap
  `CWK_ASSERT_IMP(a_reload_phase, clk, rst_n, out_valid && out_hold_reload, out_keyer_phase_out != PH_IDLE)

  // after an accept the input side only backs up behind a waiting result
  `CWK_ASSERT_NXT(a_flow, clk, rst_n, in_valid && !in_stall && !out_stall, !in_stall || out_valid)

endmodule

bind cw_keyer_envelope cwk_checker u_cwk_checker (.*);

// ----- dv/cwk_envelope_checker.sv -----
// cwk_envelope_checker: watches the word, result and register channels of
// cw_keyer_envelope, predicts every envelope word and compares it on arrival
// depends on cwk_pkg for widths, phase codes and register indexes
`timescale 1ns / 1ps

module cwk_envelope_checker import cwk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [31:0]       in_now_ms,
  input  logic [PWR_W-1:0]  in_target_power,
  input  logic              in_dot_key,
  input  logic              in_dash_key,
  input  logic              in_serial_key,
  input  logic              in_ptt_key,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [PWR_W-1:0]  out_envelope,
  input  logic              out_hold_reload,
  input  logic [15:0]       out_hold_value,
  input  logic [1:0]        out_keyer_phase_out,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int unsigned       mismatch_count,
  output int unsigned       pending_words,
  output int unsigned       words_checked,
  output int unsigned       elements_started
);

  typedef struct packed {
    logic [PWR_W-1:0] envelope;
    logic             reload;
    logic [15:0]      hold;
    logic [1:0]       phase;
  } envelope_word_t;

  envelope_word_t expected_envelopes[$];

  logic             keyer_on;
  logic [6:0]       speed_wpm;
  logic [15:0]      hold_ms;
  logic [1:0]       phase;
  logic [31:0]      start_ms;
  logic [PWR_W-1:0] level;
  int unsigned      n_bad = 0;
  int unsigned      n_checked = 0;
  int unsigned      n_started = 0;

  // rise by 1% of target; wider sum since level + step can pass 15 bits
  function automatic logic [PWR_W-1:0] ramp_to(input logic [PWR_W-1:0] power);
    logic [16:0] sum;
    sum = 17'(level);
    if (level < power) sum = 17'(level) + 17'(power / 15'd100);
    if (sum > 17'(power)) sum = 17'(power);
    level = sum[PWR_W-1:0];
    return level;
  endfunction

  function automatic logic [PWR_W-1:0] decay(input logic [PWR_W-1:0] power);
    logic [PWR_W-1:0] dec;
    dec = power / 15'd100;
    if (level > dec) level = level - dec;
    else level = '0;
    return level;
  endfunction

  // element end time wraps at 32 bits; equal to now means neither test holds
  function automatic logic still_running(input logic [31:0] len, input logic [31:0] now);
    logic [31:0] stop;
    stop = start_ms + len;
    return stop > now;
  endfunction

  function automatic logic has_ended(input logic [31:0] len, input logic [31:0] now);
    logic [31:0] stop;
    stop = start_ms + len;
    return stop < now;
  endfunction

  function automatic envelope_word_t predict_envelope(
    input logic [31:0] now, input logic [PWR_W-1:0] power,
    input logic dot, input logic dash, input logic serial, input logic ptt);
    envelope_word_t w;
    logic [31:0]    dot_ms;
    logic [31:0]    dash_ms;
    logic           done;
    w.reload   = 1'b0;
    w.hold     = hold_ms;
    w.envelope = '0;
    if (!keyer_on) begin
      if (dot || dash || serial || ptt) w.envelope = ramp_to(power);
      else w.envelope = decay(power);
    end else begin
      dot_ms  = 32'd1200 / ((speed_wpm == 7'd0) ? 32'd1 : 32'(speed_wpm));
      dash_ms = dot_ms * 32'd3;
      done    = 1'b0;
      if (phase == PH_IDLE && dot) begin
        start_ms = now;
        phase    = PH_DOT;
        n_started++;
      end
      if (phase == PH_DOT && still_running(dot_ms, now)) begin
        w.reload   = 1'b1;
        w.envelope = ramp_to(power);
        done       = 1'b1;
      end
      if (!done && phase == PH_DOT && has_ended(dot_ms, now)) begin
        start_ms = now;
        phase    = PH_SPACE;
      end
      if (!done && phase == PH_IDLE && dash) begin
        start_ms = now;
        phase    = PH_DASH;
        n_started++;
      end
      if (!done && phase == PH_DASH && still_running(dash_ms, now)) begin
        w.reload   = 1'b1;
        w.envelope = ramp_to(power);
        done       = 1'b1;
      end
      if (!done && phase == PH_DASH && has_ended(dash_ms, now)) begin
        start_ms = now;
        phase    = PH_SPACE;
      end
      if (!done && phase == PH_SPACE && still_running(dot_ms, now)) begin
        w.reload   = 1'b1;
        w.envelope = decay(power);
        done       = 1'b1;
      end
      if (!done && phase == PH_SPACE && has_ended(dot_ms, now)) phase = PH_IDLE;
      if (!done) w.envelope = decay(power);
    end
    w.phase = phase;
    return w;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      n_bad++;
      if (n_bad <= 10)
        $display("mismatch on word %0d, %s: expected %0d, got %0d",
                 n_checked, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    envelope_word_t want;
    if (!rst_n) begin
      keyer_on  = 1'b0;
      speed_wpm = WPM_RESET;
      hold_ms   = HOLD_RESET;
      phase     = PH_IDLE;
      start_ms  = '0;
      level     = '0;
      expected_envelopes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEYER_EN: keyer_on = cfg_data[0];
          CFG_WPM:      speed_wpm = cfg_data[6:0];
          CFG_HOLD:     hold_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_envelopes.push_back(predict_envelope(in_now_ms, in_target_power,
          in_dot_key, in_dash_key, in_serial_key, in_ptt_key));
      if (out_valid && !out_stall) begin
        if (expected_envelopes.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected envelope word %0d: envelope %0d, phase %0d",
                     n_checked, out_envelope, out_keyer_phase_out);
        end else begin
          want = expected_envelopes.pop_front();
          flag_field("envelope", 32'(want.envelope), 32'(out_envelope));
          flag_field("hold_reload", 32'(want.reload), 32'(out_hold_reload));
          flag_field("hold_value", 32'(want.hold), 32'(out_hold_value));
          flag_field("keyer_phase_out", 32'(want.phase), 32'(out_keyer_phase_out));
        end
        n_checked++;
      end
    end
    // registered so the top reads a settled value at each edge
    mismatch_count   <= n_bad;
    pending_words    <= expected_envelopes.size();
    words_checked    <= n_checked;
    elements_started <= n_started;
  end

endmodule

// ----- dv/tb_cw_keyer_envelope.sv -----
// tb_cw_keyer_envelope: clock, reset, register writes and word traffic for
// cw_keyer_envelope, with cwk_envelope_checker alongside; depends on cwk_pkg
`timescale 1ns / 1ps

module tb_cw_keyer_envelope;
  import cwk_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int          HOLD_OFF_CYCLES = 250;

  typedef struct packed {
    logic ptt;
    logic serial;
    logic dash;
    logic dot;
  } key_lines_t;

  localparam key_lines_t KEY_NONE   = 4'b0000;
  localparam key_lines_t KEY_DOT    = 4'b0001;
  localparam key_lines_t KEY_DASH   = 4'b0010;
  localparam key_lines_t KEY_SERIAL = 4'b0100;
  localparam key_lines_t KEY_PTT    = 4'b1000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [31:0]      in_now_ms;
  logic [PWR_W-1:0] in_target_power;
  logic             in_dot_key;
  logic             in_dash_key;
  logic             in_serial_key;
  logic             in_ptt_key;
  logic             out_valid;
  logic             out_stall;
  logic [PWR_W-1:0] out_envelope;
  logic             out_hold_reload;
  logic [15:0]      out_hold_value;
  logic [1:0]       out_keyer_phase_out;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_data;

  int unsigned mismatch_count;
  int unsigned pending_words;
  int unsigned words_checked;
  int unsigned elements_started;

  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned hold_offs = 0;
  int unsigned hold_off_asks = 0;
  int          gap_pct = 20;
  int          stall_pct = 20;
  logic        quiet = 1'b0;
  logic [31:0]      clock_ms;
  logic [PWR_W-1:0] power_now = '1;
  key_lines_t       keys_now = KEY_NONE;

  cw_keyer_envelope dut (.*);

  cwk_envelope_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_offs < hold_off_asks) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_offs++;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [31:0] now, input logic [PWR_W-1:0] power,
                           input key_lines_t keys);
    in_valid        <= 1'b1;
    in_now_ms       <= now;
    in_target_power <= power;
    in_dot_key      <= keys.dot;
    in_dash_key     <= keys.dash;
    in_serial_key   <= keys.serial;
    in_ptt_key      <= keys.ptt;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic configure(input logic keyer, input logic [6:0] wpm,
                           input logic [15:0] hold);
    write_reg(CFG_KEYER_EN, {15'd0, keyer});
    write_reg(CFG_WPM, {9'd0, wpm});
    write_reg(CFG_HOLD, hold);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender back until every predicted word has been seen
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  function automatic logic [PWR_W-1:0] pick_power();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return PWR_W'($urandom_range(0, 150));
    if (roll == 3) return '1;
    return PWR_W'($urandom_range(0, 32767));
  endfunction

  task automatic run_phase(input logic keyer, input logic [6:0] wpm, input logic [15:0] hold,
                           input int count, input logic squeeze);
    int unsigned dot_ms;
    int unsigned roll;
    configure(keyer, wpm, hold);
    dot_ms   = 1200 / ((wpm == 7'd0) ? 1 : wpm);
    clock_ms = $urandom();
    if (squeeze) hold_off_asks++;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        // time moves on steadily and keys are held, so elements run their course
        clock_ms = clock_ms + $urandom_range(0, dot_ms / 4 + 2);
        if ($urandom_range(0, 7) == 0) keys_now = key_lines_t'($urandom_range(0, 15));
        if ($urandom_range(0, 15) == 0) power_now = pick_power();
        send_word(clock_ms, power_now, keys_now);
      end else if (roll < 92) begin
        clock_ms = $urandom();
        send_word(clock_ms, power_now, keys_now);
      end else begin
        send_word($urandom(), pick_power(), key_lines_t'($urandom_range(0, 15)));
      end
    end
    drain();
  endtask

  initial begin
    logic [31:0] base;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_now_ms       <= '0;
    in_target_power <= '0;
    in_dot_key      <= 1'b0;
    in_dash_key     <= 1'b0;
    in_serial_key   <= 1'b0;
    in_ptt_key      <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_KEYER_EN;
    cfg_data        <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // straight key at reset settings: ramps, clamps and saturation
    send_word(32'h0000_0000, '1, KEY_NONE);
    send_word(32'hFFFF_FFFF, '1, KEY_DOT);
    send_word(32'h0000_0001, '1, KEY_DASH);
    send_word(32'h8000_0000, '1, KEY_SERIAL);
    send_word(32'h7FFF_FFFF, '1, KEY_PTT);
    send_word(32'h0000_0002, 15'd500, KEY_PTT);
    send_word(32'h0000_0003, 15'd99, KEY_SERIAL);
    send_word(32'h0000_0004, 15'd99, KEY_NONE);
    send_word(32'h0000_0005, 15'd0, KEY_DOT);
    send_word(32'h0000_0006, 15'd200, KEY_DASH);
    send_word(32'h0000_0007, '1, KEY_NONE);
    send_word(32'h0000_0008, 15'd100, KEY_DOT | KEY_DASH | KEY_SERIAL | KEY_PTT);
    drain();

    // keyer at 100 wpm across the 32-bit wrap: dot 12 ms, dash 36 ms
    configure(1'b1, 7'd100, 16'hFFFF);
    base = 32'hFFFF_FFF0;
    send_word(base, 15'd5000, KEY_DOT);
    send_word(base + 5, 15'd5000, KEY_NONE);
    send_word(base + 12, 15'd5000, KEY_NONE);
    send_word(base + 13, 15'd5000, KEY_NONE);
    send_word(base + 25, 15'd5000, KEY_NONE);
    send_word(base + 26, 15'd5000, KEY_DASH);
    send_word(base + 40, 15'd5000, KEY_DOT | KEY_DASH);
    send_word(base + 62, 15'd5000, KEY_NONE);
    send_word(base + 63, 15'd5000, KEY_NONE);
    send_word(base + 80, 15'd5000, KEY_DOT | KEY_DASH);
    send_word(base + 200, 15'd5000, KEY_DOT | KEY_DASH);
    send_word(base + 300, 15'd5000, KEY_DOT);
    send_word(base + 301, 15'd5000, KEY_DOT | KEY_DASH);
    drain();

    gap_pct = 20; stall_pct = 20;
    run_phase(1'b0, 7'd1, 16'hFFFF, 250, 1'b0);
    gap_pct = 5; stall_pct = 10;
    run_phase(1'b1, 7'd100, 16'd0, 350, 1'b1);
    gap_pct = 30; stall_pct = 30;
    run_phase(1'b1, 7'd0, 16'd1234, 200, 1'b0);
    gap_pct = 10; stall_pct = 40;
    run_phase(1'b1, 7'd1, 16'hFFFF, 200, 1'b0);
    gap_pct = 25; stall_pct = 5;
    run_phase(1'b1, 7'($urandom_range(2, 99)), 16'($urandom()), 350, 1'b0);
    run_phase(1'b0, 7'($urandom_range(1, 100)), 16'($urandom()), 250, 1'b0);
    quiet = 1'b1;
    run_phase(1'b1, 7'd60, 16'($urandom()), 400, 1'b0);
    repeat (8) @(posedge clk);

    $display("sent %0d words, checked %0d envelope words, %0d register writes",
             words_sent, words_checked, reg_writes);
    $display("keyer elements started %0d, long output hold-offs %0d, mismatches %0d",
             elements_started, hold_offs, mismatch_count);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
